// ===== src/clle_pkg.sv =====
`timescale 1ns / 1ps

package clle_pkg;

    // pool geometry
    localparam int CELLS   = 16;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int LINK_W  = $clog2(CELLS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CELLS);

    // word fields
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int CMD_W   = 3;
    localparam int REM_W   = 5;
    localparam int STAT_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_SORTED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_ALL    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_WALK       = 3'd6;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        RES_DONE      = 2'd0,
        RES_NO_FREE   = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_EMPTY     = 2'd3
    } res_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ALLOC,
        OP_ADVANCE,
        OP_LINK_NEW,
        OP_SET_SLOT_NEW,
        OP_UNLINK,
        OP_FREE,
        OP_WALK_STEP,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        res_t   res;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic free_empty;
        logic cur_null;
        logic hops_done;
        logic ins_stop;
        logic match;
        logic removed_zero;
        logic walk_fin;
        logic out_free;
    } dp_stat_t;

    // any out-of-range link reads as null
    function automatic logic [LINK_W-1:0] link_bound(input logic [LINK_W-1:0] v);
        return (v < NULL_LINK) ? v : NULL_LINK;
    endfunction

endpackage

// ===== src/clle_dp.sv =====
`timescale 1ns / 1ps

module clle_dp
    import clle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat
);

    // cell pool
    logic [LINK_W-1:0]  links_reg  [CELLS];
    logic [VALUE_W-1:0] values_reg [CELLS];

    logic [LINK_W-1:0]  list_head_reg, list_head_next;
    logic [LINK_W-1:0]  free_head_reg, free_head_next;
    logic [LINK_W-1:0]  slot_reg, slot_next;
    logic [LINK_W-1:0]  cur_reg, cur_next;
    logic [LINK_W-1:0]  nw_reg, nw_next;
    logic [LINK_W-1:0]  hops_reg, hops_next;
    logic [REM_W-1:0]   removed_reg, removed_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [VALUE_W-1:0] elem_reg, elem_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [REM_W-1:0]   m_removed_reg, m_removed_next;
    logic               m_last_reg, m_last_next;

    logic [IDX_W-1:0]   rd_addr;
    logic [LINK_W-1:0]  rd_link;
    logic [VALUE_W-1:0] cur_value;
    logic               out_free;
    logic               walk_fin;

    logic               lk_we;
    logic [IDX_W-1:0]   lk_waddr;
    logic [LINK_W-1:0]  lk_wdata;

    // single link read port: free head on allocation, current cell otherwise
    assign rd_addr   = (cmd.op == OP_ALLOC) ? free_head_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    assign rd_link   = link_bound(links_reg[rd_addr]);
    assign cur_value = values_reg[cur_reg[IDX_W-1:0]];
    assign out_free  = !m_valid_reg || m_tready;
    assign walk_fin  = (rd_link == NULL_LINK) || (hops_reg == LINK_W'(CELLS - 1));

    // status to the controller
    always_comb begin
        stat.cmd          = cmd_reg;
        stat.free_empty   = (free_head_reg >= NULL_LINK);
        stat.cur_null     = (cur_reg == NULL_LINK);
        stat.hops_done    = (hops_reg == NULL_LINK);
        stat.ins_stop     = (cmd_reg == CMD_INS_HEAD)
                          || ((cmd_reg == CMD_INS_POS) && (32'(hops_reg) >= 32'(pos_reg)))
                          || ((cmd_reg == CMD_INS_SORTED)
                              && !($signed(cur_value) < $signed(elem_reg)));
        stat.match        = (cur_value == elem_reg);
        stat.removed_zero = (removed_reg == '0);
        stat.walk_fin     = walk_fin;
        stat.out_free     = out_free;
    end

    // link store write port and head update
    always_comb begin
        lk_we          = 1'b0;
        lk_waddr       = nw_reg[IDX_W-1:0];
        lk_wdata       = cur_reg;
        list_head_next = list_head_reg;
        case (cmd.op)
            OP_LINK_NEW: begin
                lk_we = 1'b1;
            end
            OP_FREE: begin
                lk_we    = 1'b1;
                lk_wdata = link_bound(free_head_reg);
            end
            OP_SET_SLOT_NEW: begin
                if (slot_reg < NULL_LINK) begin
                    lk_we    = 1'b1;
                    lk_waddr = slot_reg[IDX_W-1:0];
                    lk_wdata = nw_reg;
                end else begin
                    list_head_next = nw_reg;
                end
            end
            OP_UNLINK: begin
                if (slot_reg < NULL_LINK) begin
                    lk_we    = 1'b1;
                    lk_waddr = slot_reg[IDX_W-1:0];
                    lk_wdata = rd_link;
                end else begin
                    list_head_next = rd_link;
                end
            end
            default: begin
            end
        endcase
    end

    // traversal and bookkeeping registers
    always_comb begin
        free_head_next = free_head_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        nw_next        = nw_reg;
        hops_next      = hops_reg;
        removed_next   = removed_reg;
        cmd_next       = cmd_reg;
        elem_next      = elem_reg;
        pos_next       = pos_reg;
        case (cmd.op)
            OP_LOAD: begin
                cmd_next     = s_tuser;
                elem_next    = s_tdata[VALUE_W-1:0];
                pos_next     = s_tdata[VALUE_W +: POS_W];
                slot_next    = NULL_LINK;
                cur_next     = link_bound(list_head_reg);
                hops_next    = '0;
                removed_next = '0;
            end
            OP_ALLOC: begin
                nw_next        = free_head_reg;
                free_head_next = rd_link;
            end
            OP_ADVANCE: begin
                slot_next = cur_reg;
                cur_next  = rd_link;
                hops_next = hops_reg + 1'b1;
            end
            OP_UNLINK: begin
                nw_next  = cur_reg;
                cur_next = rd_link;
            end
            OP_FREE: begin
                free_head_next = nw_reg;
                removed_next   = removed_reg + 1'b1;
                hops_next      = hops_reg + 1'b1;
            end
            OP_WALK_STEP: begin
                cur_next  = rd_link;
                hops_next = hops_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output word register
    always_comb begin
        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_value_next   = m_value_reg;
        m_removed_next = m_removed_reg;
        m_last_next    = m_last_reg;
        case (cmd.op)
            OP_WALK_STEP: begin
                m_valid_next   = 1'b1;
                m_status_next  = RES_DONE;
                m_value_next   = cur_value;
                m_removed_next = '0;
                m_last_next    = walk_fin;
            end
            OP_RESULT: begin
                m_valid_next   = 1'b1;
                m_status_next  = cmd.res;
                m_value_next   = '0;
                m_removed_next = removed_reg;
                m_last_next    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_head_reg <= NULL_LINK;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        cur_reg       <= cur_next;
        nw_reg        <= nw_next;
        hops_reg      <= hops_next;
        removed_reg   <= removed_next;
        cmd_reg       <= cmd_next;
        elem_reg      <= elem_next;
        pos_reg       <= pos_next;
        m_status_reg  <= m_status_next;
        m_value_reg   <= m_value_next;
        m_removed_reg <= m_removed_next;
        m_last_reg    <= m_last_next;
    end

    // link store, chained as a free list at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                links_reg[i] <= LINK_W'(i + 1);
            end
        end else if (lk_we) begin
            links_reg[lk_waddr] <= lk_wdata;
        end
    end

    // value store
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_ALLOC) begin
            values_reg[free_head_reg[IDX_W-1:0]] <= elem_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_removed_reg, m_value_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    // allocation only from a non-empty free list
    a_alloc_has_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_ALLOC |-> free_head_reg < NULL_LINK)
        else $error("allocation with empty free list");

    // output register is never overwritten while a word waits
    a_out_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_RESULT || cmd.op == OP_WALK_STEP) |-> out_free)
        else $error("output word overwritten");

    // stepping along the list needs a live cell
    a_advance_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ADVANCE || cmd.op == OP_UNLINK || cmd.op == OP_WALK_STEP)
        |-> cur_reg != NULL_LINK)
        else $error("step from null cell");

    // an unlinked cell is released right after and is no longer current
    a_unlink_then_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_UNLINK |=> (cmd.op == OP_FREE && nw_reg != cur_reg))
        else $error("unlinked cell not released");

endmodule

// ===== src/clle_ctrl.sv =====
`timescale 1ns / 1ps

module clle_ctrl
    import clle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t dp_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_INS_WALK = 8'b0000_0100,
        S_INS_HEAD = 8'b0000_1000,
        S_DEL_WALK = 8'b0001_0000,
        S_DEL_FREE = 8'b0010_0000,
        S_WALK     = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    // command sequencing
    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        dp_cmd.op  = OP_NONE;
        dp_cmd.res = res_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.op  = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.cmd inside {CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS,
                                     CMD_INS_SORTED}) begin
                    if (stat.free_empty) begin
                        res_next   = RES_NO_FREE;
                        state_next = S_RESULT;
                    end else begin
                        dp_cmd.op  = OP_ALLOC;
                        state_next = S_INS_WALK;
                    end
                end else if (stat.cmd inside {CMD_DEL_FIRST, CMD_DEL_ALL}) begin
                    state_next = S_DEL_WALK;
                end else if (stat.cmd == CMD_WALK) begin
                    if (stat.cur_null) begin
                        res_next   = RES_EMPTY;
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_WALK;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_INS_WALK: begin
                if (stat.cur_null || stat.hops_done || stat.ins_stop) begin
                    dp_cmd.op  = OP_LINK_NEW;
                    state_next = S_INS_HEAD;
                end else begin
                    dp_cmd.op = OP_ADVANCE;
                end
            end
            S_INS_HEAD: begin
                dp_cmd.op  = OP_SET_SLOT_NEW;
                res_next   = RES_DONE;
                state_next = S_RESULT;
            end
            S_DEL_WALK: begin
                if (stat.cur_null || stat.hops_done) begin
                    res_next   = stat.removed_zero ? RES_NOT_FOUND : RES_DONE;
                    state_next = S_RESULT;
                end else if (stat.match) begin
                    dp_cmd.op  = OP_UNLINK;
                    state_next = S_DEL_FREE;
                end else begin
                    dp_cmd.op = OP_ADVANCE;
                end
            end
            S_DEL_FREE: begin
                dp_cmd.op = OP_FREE;
                if (stat.cmd == CMD_DEL_FIRST) begin
                    res_next   = RES_DONE;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_DEL_WALK;
                end
            end
            S_WALK: begin
                if (stat.out_free) begin
                    dp_cmd.op = OP_WALK_STEP;
                    if (stat.walk_fin) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    dp_cmd.op  = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= RES_DONE;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

// ===== src/cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps

// Linked list of signed 32-bit values kept in a pool of 16 cells, with unused
// cells chained on a free list. Commands arrive on the s_ side (kind in tuser)
// and results leave on the m_ side with tlast on the final word of a command.
// One command is processed at a time; the input is ready again once the last
// result word is loaded into the output register. Timing is set by the link
// store, read once per cycle, so a traversal moves one cell per clock: an
// insert allocates a cell (or reports that none is free), walks to its place,
// links the cell in and then reports; a delete unlinks and frees each matching
// cell as it walks, a delete-first stopping at its first match; and a walk
// emits one word per cycle when the consumer keeps up. A command code of 7 is
// dropped with no result.
module cursor_linked_list_engine
    import clle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // item_value[31:0], position[39:32]
    input  logic [CMD_W-1:0]     s_tuser,   // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status[1:0], out_value[33:2],
                                            // removed_count[38:34], zero[39]
    output logic                 m_tlast
);

    ctrl_cmd_t dp_cmd;
    dp_stat_t  dp_stat;

    // sequencer
    clle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    // cell pool, pointers and output register
    clle_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

endmodule
